[src/wpd_pkg.sv]
// Package: types, codes and constants of the WAV PCM16 parser and downmix unit.
package wpd_pkg;

	localparam logic [31:0] TagRiff = 32'h4646_4952;
	localparam logic [31:0] TagWave = 32'h4556_4157;
	localparam logic [31:0] TagFmt  = 32'h2074_6D66;
	localparam logic [31:0] TagData = 32'h6174_6164;

	localparam int ResultWidth = 2 + 16 + 16 + 32 + 31;

	typedef enum logic [1:0] {
		KIND_FORMAT = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_END    = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_RIFF  = 3'd0,
		PH_CHUNK = 3'd1,
		PH_FMT   = 3'd2,
		PH_SKIP  = 3'd3,
		PH_DATA  = 3'd4,
		PH_WAIT  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT0,
		ST_EMIT1
	} ctrl_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic parse;      // handle the captured byte
		logic div_start;  // begin the frame average
		logic div_step;   // one divider iteration
		logic finish;     // apply end/error, reset on end of stream
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic need_div;   // the parsed byte completed a frame
		logic div_done;
		logic [1:0] n_res; // results caused by this byte
	} dp_sts_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] mono_sample;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [30:0] frames_done;
	} result_t;

endpackage

[src/wav_pcm16_stream_parser_downmix_unit.sv]
// Top level: WAV PCM16 stream parser with mono downmix.
//  channel | dir | tdata                         | tuser | tlast
//  s_axis  | in  | data_byte[7:0]                | -     | end_of_stream
//  m_axis  | out | mono[15:0] ch[31:16] rate[63:32] frames[94:64] | kind[1:0] | last_of_run
// Each byte is parsed, then runs through the serial divider when it closes a frame,
// then delivers its results. The serial 32-step divider sets the frame cost.
// Reset clears parser state to expecting the RIFF header.
// Output stalls hold the result and block new input until delivered.
module wav_pcm16_stream_parser_downmix_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [95:0] m_tdata,  // mono_sample, channel_count, rate_hz, frames_done, pad
	output logic [1:0] m_tuser,   // kind
	output logic m_tlast
);
	import wpd_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	result_t r0, r1, r;
	logic sel1, s_fire;

	assign s_fire = s_tvalid && s_tready;

	wpd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_byte(s_tdata), .in_eos(s_tlast),
		.in_load(s_fire), .cmd(cmd), .sts(sts), .res0(r0), .res1(r1)
	);

	wpd_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_fire(s_fire), .s_ready(s_tready),
		.m_ready(m_tready), .m_valid(m_tvalid), .m_last(m_tlast), .sel1(sel1),
		.cmd(cmd), .sts(sts)
	);

	assign r = sel1 ? r1 : r0;
	assign m_tuser = r.kind;
	assign m_tdata = {1'b0, r.frames_done, r.rate_hz, r.channel_count, r.mono_sample};

endmodule

[src/wpd_datapath.sv]
// Datapath: header parse registers, frame accumulator, serial divider and results.
module wpd_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] in_byte,
	input  logic in_eos,
	input  logic in_load,
	input  wpd_pkg::dp_cmd_t cmd,
	output wpd_pkg::dp_sts_t sts,
	output wpd_pkg::result_t res0,
	output wpd_pkg::result_t res1
);
	import wpd_pkg::*;

	phase_t phase_q;
	logic [4:0] field_index_q;
	logic [63:0] header_shift_q;
	logic [31:0] skip_remaining_q;
	logic fmt_seen_q;
	logic [15:0] format_code_q, channels_held_q, bits_held_q, channel_index_q;
	logic [31:0] rate_held_q;
	logic [7:0] low_byte_q, byte_q;
	logic byte_parity_q, eos_q;
	logic signed [31:0] frame_sum_q;
	logic [30:0] samples_left_q, frame_total_q;
	logic err_q, ended_q, fmt_rep_q, need_div_q;

	// Divider registers: magnitude restoring division, 32 bits
	logic [31:0] quo_q, rem_q;
	logic [5:0] div_cnt_q;
	logic neg_q, div_busy_q;
	logic [16:0] nch_c;
	logic [32:0] trial_c;

	logic [63:0] hs_c;
	assign hs_c = {byte_q, header_shift_q[63:8]};
	assign nch_c = (channels_held_q == 16'd0) ? 17'd1 : {1'b0, channels_held_q};
	assign trial_c = {rem_q, quo_q[31]} - {16'd0, nch_c};

	// Capture the accepted byte
	always_ff @(posedge clk) begin
		if (in_load) begin
			byte_q <= in_byte;
			eos_q <= in_eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			field_index_q <= '0;
			header_shift_q <= '0;
			skip_remaining_q <= '0;
			fmt_seen_q <= 1'b0;
			format_code_q <= '0;
			channels_held_q <= '0;
			rate_held_q <= '0;
			bits_held_q <= '0;
			low_byte_q <= '0;
			byte_parity_q <= 1'b0;
			frame_sum_q <= '0;
			channel_index_q <= '0;
			samples_left_q <= '0;
			frame_total_q <= '0;
			err_q <= 1'b0;
			ended_q <= 1'b0;
			fmt_rep_q <= 1'b0;
			need_div_q <= 1'b0;
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			neg_q <= 1'b0;
		end else begin
			if (cmd.parse) begin
				logic [31:0] id, sz;
				logic [15:0] raw;
				logic signed [31:0] nsum;
				logic e, en, nd, fr, td;
				id = hs_c[31:0];
				sz = hs_c[63:32];
				e = 1'b0; en = 1'b0; nd = 1'b0; fr = 1'b0; td = 1'b0;
				raw = {byte_q, low_byte_q};
				nsum = frame_sum_q + {{16{raw[15]}}, raw};
				header_shift_q <= hs_c;
				case (phase_q)
					PH_RIFF: begin
						if (field_index_q == 5'd3 && sz != TagRiff) e = 1'b1;
						else if (field_index_q == 5'd11) begin
							if (sz != TagWave) e = 1'b1;
							else begin
								phase_q <= PH_CHUNK;
								field_index_q <= '0;
							end
						end else field_index_q <= field_index_q + 5'd1;
					end
					PH_CHUNK: begin
						if (field_index_q < 5'd7) field_index_q <= field_index_q + 5'd1;
						else begin
							field_index_q <= '0;
							if (id == TagFmt) begin
								if (sz < 32'd16) e = 1'b1;
								else begin
									skip_remaining_q <= sz - 32'd16;
									format_code_q <= '0;
									channels_held_q <= '0;
									rate_held_q <= '0;
									bits_held_q <= '0;
									phase_q <= PH_FMT;
								end
							end else if (id == TagData) begin
								if (!fmt_seen_q || format_code_q != 16'd1 || bits_held_q != 16'd16)
									e = 1'b1;
								else begin
									fr = 1'b1;
									samples_left_q <= sz[31:1];
									frame_sum_q <= '0;
									channel_index_q <= '0;
									byte_parity_q <= 1'b0;
									frame_total_q <= '0;
									if (sz[31:1] == 31'd0) en = 1'b1;
									else begin
										phase_q <= PH_DATA;
										td = 1'b1;
									end
								end
							end else begin
								skip_remaining_q <= (sz + 32'd1) & ~32'd1;
								if (((sz + 32'd1) & ~32'd1) != 32'd0) phase_q <= PH_SKIP;
							end
						end
					end
					PH_FMT: begin
						case (field_index_q)
							5'd0: format_code_q[7:0] <= byte_q;
							5'd1: format_code_q[15:8] <= byte_q;
							5'd2: channels_held_q[7:0] <= byte_q;
							5'd3: channels_held_q[15:8] <= byte_q;
							5'd4: rate_held_q[7:0] <= byte_q;
							5'd5: rate_held_q[15:8] <= byte_q;
							5'd6: rate_held_q[23:16] <= byte_q;
							5'd7: rate_held_q[31:24] <= byte_q;
							5'd14: bits_held_q[7:0] <= byte_q;
							5'd15: bits_held_q[15:8] <= byte_q;
							default: ;
						endcase
						if (field_index_q >= 5'd15) begin
							fmt_seen_q <= 1'b1;
							field_index_q <= '0;
							phase_q <= (skip_remaining_q != 0) ? PH_SKIP : PH_CHUNK;
						end else field_index_q <= field_index_q + 5'd1;
					end
					PH_SKIP: begin
						skip_remaining_q <= skip_remaining_q - 32'd1;
						if (skip_remaining_q == 32'd1) begin
							phase_q <= PH_CHUNK;
							field_index_q <= '0;
						end
					end
					PH_DATA: begin
						if (!byte_parity_q) begin
							low_byte_q <= byte_q;
							byte_parity_q <= 1'b1;
						end else begin
							byte_parity_q <= 1'b0;
							samples_left_q <= samples_left_q - 31'd1;
							if ({1'b0, channel_index_q + 16'd1} >= nch_c) begin
								nd = 1'b1;
								frame_total_q <= frame_total_q + 31'd1;
								frame_sum_q <= '0;
								channel_index_q <= '0;
								neg_q <= nsum[31];
								quo_q <= nsum[31] ? 32'd0 - nsum : nsum;
							end else begin
								frame_sum_q <= nsum;
								channel_index_q <= channel_index_q + 16'd1;
							end
							if (samples_left_q == 31'd1) en = 1'b1;
						end
					end
					default: ;
				endcase
				// End of stream: end report inside data, error before data
				if (eos_q && !e && !en) begin
					if (phase_q == PH_DATA || td) en = 1'b1;
					else if (phase_q <= PH_SKIP) e = 1'b1;
				end
				err_q <= e;
				ended_q <= en;
				fmt_rep_q <= fr;
				need_div_q <= nd;
			end
			// Serial divider: one quotient bit per step
			if (cmd.div_start) begin
				rem_q <= '0;
				div_cnt_q <= '0;
				div_busy_q <= 1'b1;
			end else if (cmd.div_step && div_busy_q) begin
				if (!trial_c[32]) begin
					rem_q <= trial_c[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quo_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
				div_cnt_q <= div_cnt_q + 6'd1;
				if (div_cnt_q == 6'd31) div_busy_q <= 1'b0;
			end
			// Close the byte: wait phase on error or end, reset on end of stream
			if (cmd.finish) begin
				if (eos_q) begin
					phase_q <= PH_RIFF;
					field_index_q <= '0;
					header_shift_q <= '0;
					skip_remaining_q <= '0;
					fmt_seen_q <= 1'b0;
					format_code_q <= '0;
					channels_held_q <= '0;
					rate_held_q <= '0;
					bits_held_q <= '0;
					low_byte_q <= '0;
					byte_parity_q <= 1'b0;
					frame_sum_q <= '0;
					channel_index_q <= '0;
					samples_left_q <= '0;
					frame_total_q <= '0;
				end else if (err_q || ended_q) phase_q <= PH_WAIT;
			end
		end
	end

	// Order results: first report or sample, then error or end
	always_comb begin
		result_t a, b;
		logic [15:0] q16;
		q16 = neg_q ? 16'd0 - quo_q[15:0] : quo_q[15:0];
		a = '0;
		b = '0;
		if (err_q) b.kind = KIND_ERROR;
		else begin
			b.kind = KIND_END;
			b.frames_done = frame_total_q;
		end
		if (fmt_rep_q) begin
			a.kind = KIND_FORMAT;
			a.channel_count = channels_held_q;
			a.rate_hz = rate_held_q;
		end else if (need_div_q) begin
			a.kind = KIND_SAMPLE;
			a.mono_sample = q16;
		end else a = b;
		res0 = a;
		res1 = b;
		sts.need_div = need_div_q;
		sts.div_done = !div_busy_q;
		sts.n_res = 2'({1'b0, fmt_rep_q | need_div_q} + {1'b0, err_q | ended_q});
	end

endmodule

[src/wpd_controller.sv]
// Controller: sequences parse, divide and result delivery for each byte.
module wpd_controller (
	input  logic clk,
	input  logic arst_n,
	input  logic s_fire,
	output logic s_ready,
	input  logic m_ready,
	output logic m_valid,
	output logic m_last,
	output logic sel1,
	output wpd_pkg::dp_cmd_t cmd,
	input  wpd_pkg::dp_sts_t sts
);
	import wpd_pkg::*;

	ctrl_state_t state_q, state_d;
	logic parse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			parse_q <= 1'b0;
		end else begin
			state_q <= state_d;
			parse_q <= s_fire;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_ready = 1'b0;
		m_valid = 1'b0;
		m_last = 1'b0;
		sel1 = 1'b0;
		cmd.parse = parse_q;
		case (state_q)
			ST_IDLE: begin
				s_ready = !parse_q;
				if (s_fire) state_d = ST_DIV;
			end
			ST_DIV: begin
				// while parse_q is set the byte is parsed and the divider started; afterwards step it if a frame closed
				if (sts.need_div && !parse_q) cmd.div_step = 1'b1;
				if (parse_q) ;
				else if (sts.need_div && !sts.div_done) cmd.div_step = 1'b1;
				else if (sts.n_res == 2'd0) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end else state_d = ST_EMIT0;
			end
			ST_EMIT0: begin
				m_valid = 1'b1;
				m_last = (sts.n_res == 2'd1);
				if (m_ready) begin
					if (sts.n_res == 2'd1) begin
						cmd.finish = 1'b1;
						state_d = ST_IDLE;
					end else state_d = ST_EMIT1;
				end
			end
			ST_EMIT1: begin
				m_valid = 1'b1;
				m_last = 1'b1;
				sel1 = 1'b1;
				if (m_ready) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.div_start = parse_q;
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_ready) else $error("accept while busy");
	a_last_second: assert property (@(posedge clk) disable iff (!arst_n)
		sel1 |-> m_last) else $error("second result not last");
	a_emit_has_res: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid |-> sts.n_res != 2'd0) else $error("emit without result");
`endif

endmodule

[tb/sv/wav_pcm16_stream_parser_downmix_unit_check.sv]
// Checker: predicts the parser results from the input stream and compares them on the output.
`timescale 1ns / 1ps

module wav_pcm16_stream_parser_downmix_unit_check
	import wpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		kind_t       kind;
		logic [15:0] mono;
		logic [15:0] chans;
		logic [31:0] rate;
		logic [30:0] frames;
		logic        last;
	} report_t;

	report_t reports_due[$];

	// Parser mirror
	phase_t      phase;
	logic [4:0]  fidx;
	logic [63:0] hdr;
	logic [31:0] skip_left;
	logic        fmt_ok;
	logic [15:0] fmt_code;
	logic [15:0] chans;
	logic [31:0] rate;
	logic [15:0] bits;
	logic [7:0]  lo_byte;
	logic        odd_byte;
	int          sum;
	logic [15:0] ch_idx;
	logic [30:0] samples_left;
	logic [30:0] frame_cnt;

	function automatic report_t mk(kind_t k, logic [15:0] m, logic [15:0] c,
			logic [31:0] r, logic [30:0] f);
		report_t x;
		x.kind = k; x.mono = m; x.chans = c; x.rate = r; x.frames = f; x.last = 1'b0;
		return x;
	endfunction

	task automatic clear_parser();
		phase = PH_RIFF; fidx = '0; hdr = '0; skip_left = '0; fmt_ok = 1'b0;
		fmt_code = '0; chans = '0; rate = '0; bits = '0; lo_byte = '0; odd_byte = 1'b0;
		sum = 0; ch_idx = '0; samples_left = '0; frame_cnt = '0;
	endtask

	// Advance the mirror by one byte and queue the results it causes
	task automatic parse_byte(logic [7:0] b, logic eos);
		report_t     outs[$];
		logic        err, ended;
		logic [31:0] id, size, nch;
		logic [15:0] raw;
		int          avg;
		err = 1'b0; ended = 1'b0;
		hdr = {b, hdr[63:8]};
		case (phase)
			PH_RIFF: begin
				if (fidx == 3 && hdr[63:32] != TagRiff) err = 1'b1;
				else if (fidx == 11) begin
					if (hdr[63:32] != TagWave) err = 1'b1;
					else begin phase = PH_CHUNK; fidx = '0; end
				end else fidx = fidx + 1'b1;
			end
			PH_CHUNK: begin
				if (fidx < 7) fidx = fidx + 1'b1;
				else begin
					id = hdr[31:0]; size = hdr[63:32]; fidx = '0;
					if (id == TagFmt) begin
						if (size < 16) err = 1'b1;
						else begin
							skip_left = size - 16;
							fmt_code = '0; chans = '0; rate = '0; bits = '0;
							phase = PH_FMT;
						end
					end else if (id == TagData) begin
						if (!fmt_ok || fmt_code != 1 || bits != 16) err = 1'b1;
						else begin
							outs.push_back(mk(KIND_FORMAT, '0, chans, rate, '0));
							samples_left = size[31:1];
							sum = 0; ch_idx = '0; odd_byte = 1'b0; frame_cnt = '0;
							if (samples_left == 0) ended = 1'b1;
							else phase = PH_DATA;
						end
					end else begin
						skip_left = (size + 1) & ~32'd1;
						if (skip_left != 0) phase = PH_SKIP;
					end
				end
			end
			PH_FMT: begin
				if (fidx < 2) fmt_code[8*fidx[0] +: 8] = b;
				else if (fidx < 4) chans[8*(fidx[0]) +: 8] = b;
				else if (fidx < 8) rate[8*(fidx[1:0]) +: 8] = b;
				else if (fidx >= 14 && fidx < 16) bits[8*fidx[0] +: 8] = b;
				if (fidx >= 15) begin
					fmt_ok = 1'b1; fidx = '0;
					phase = (skip_left != 0) ? PH_SKIP : PH_CHUNK;
				end else fidx = fidx + 1'b1;
			end
			PH_SKIP: begin
				skip_left = skip_left - 1;
				if (skip_left == 0) begin phase = PH_CHUNK; fidx = '0; end
			end
			PH_DATA: begin
				if (!odd_byte) begin
					lo_byte = b; odd_byte = 1'b1;
				end else begin
					raw = {b, lo_byte};
					nch = (chans != 0) ? chans : 32'd1;
					odd_byte = 1'b0;
					samples_left = samples_left - 1'b1;
					sum = sum + int'($signed(raw));
					ch_idx = ch_idx + 1'b1;
					if (ch_idx >= nch) begin
						avg = sum / int'(nch);
						outs.push_back(mk(KIND_SAMPLE, avg[15:0], '0, '0, '0));
						frame_cnt = frame_cnt + 1'b1;
						sum = 0; ch_idx = '0;
					end
					if (samples_left == 0) ended = 1'b1;
				end
			end
			default: ;
		endcase
		if (eos && !err && !ended) begin
			if (phase == PH_DATA) ended = 1'b1;
			else if (phase <= PH_SKIP) err = 1'b1;
		end
		if (err) begin outs.push_back(mk(KIND_ERROR, '0, '0, '0, '0)); phase = PH_WAIT; end
		if (ended) begin
			outs.push_back(mk(KIND_END, '0, '0, '0, frame_cnt)); phase = PH_WAIT;
		end
		if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
		foreach (outs[i]) reports_due.push_back(outs[i]);
		if (eos) clear_parser();
	endtask

	// Hold expectations and compare each delivered result with the oldest one
	always @(posedge clk or negedge arst_n) begin
		report_t e;
		if (!arst_n) begin
			clear_parser();
			reports_due.delete();
			fail_count <= 0;
			pending = 0;
		end else begin
			if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					$error("unexpected result kind=%0d", m_tuser);
					fail_count <= fail_count + 1;
				end else begin
					e = reports_due.pop_front();
					if (m_tuser != e.kind || m_tdata[15:0] != e.mono ||
							m_tdata[31:16] != e.chans || m_tdata[63:32] != e.rate ||
							m_tdata[94:64] != e.frames || m_tlast != e.last)
						fail_count <= fail_count + 1;
					if (m_tuser != e.kind)
						$error("kind: expected %0d, got %0d", e.kind, m_tuser);
					if (m_tdata[15:0] != e.mono)
						$error("mono_sample: expected %0d, got %0d",
							$signed(e.mono), $signed(m_tdata[15:0]));
					if (m_tdata[31:16] != e.chans)
						$error("channel_count: expected %0d, got %0d", e.chans, m_tdata[31:16]);
					if (m_tdata[63:32] != e.rate)
						$error("rate_hz: expected %0d, got %0d", e.rate, m_tdata[63:32]);
					if (m_tdata[94:64] != e.frames)
						$error("frames_done: expected %0d, got %0d", e.frames, m_tdata[94:64]);
					if (m_tlast != e.last)
						$error("last_of_run: expected %0d, got %0d", e.last, m_tlast);
				end
			end
			pending = reports_due.size();
		end
	end

endmodule

[tb/sv/wav_pcm16_stream_parser_downmix_unit_test.sv]
// Testbench top: drives WAV byte streams into the parser and gives the verdict.
`timescale 1ns / 1ps

module wav_pcm16_stream_parser_downmix_unit_test;
	import wpd_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	int          fail_count;
	int          pending;

	logic [7:0] file_bytes[$];
	int         bytes_sent = 0;
	bit         calm = 1'b0;

	// File flaws injected by the generator
	typedef enum int {
		FL_NONE, FL_RIFF, FL_WAVE, FL_FMT_SHORT, FL_NO_FMT, FL_FORMAT, FL_BITS,
		FL_TRUNC, FL_NOISE
	} flaw_t;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	wav_pcm16_stream_parser_downmix_unit dut (.*);

	wav_pcm16_stream_parser_downmix_unit_check chk (.*);

	// Stall the result side at random
	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= 14);

	task automatic put16(logic [15:0] v);
		file_bytes.push_back(v[7:0]); file_bytes.push_back(v[15:8]);
	endtask

	task automatic put32(logic [31:0] v);
		put16(v[15:0]); put16(v[31:16]);
	endtask

	// Build one file: header, optional filler chunk, fmt (absent for FL_NO_FMT), data with samples, or random noise
	task automatic build_file(flaw_t flaw, logic [15:0] nch, int nsamp, int odd_tail,
			int extra_fmt, bit filler);
		int k;
		file_bytes.delete();
		if (flaw == FL_NOISE) begin
			k = $urandom_range(40, 1);
			repeat (k) file_bytes.push_back(8'($urandom()));
			return;
		end
		put32(flaw == FL_RIFF ? TagRiff ^ (32'd1 << $urandom_range(31)) : TagRiff);
		put32($urandom());
		put32(flaw == FL_WAVE ? TagWave ^ (32'd1 << $urandom_range(31)) : TagWave);
		if (filler) begin
			k = $urandom_range(7);
			put32($urandom()); put32(32'(k));
			repeat (k + (k & 1)) file_bytes.push_back(8'($urandom()));
		end
		if (flaw != FL_NO_FMT) begin
			put32(TagFmt);
			put32(flaw == FL_FMT_SHORT ? $urandom_range(15) : 32'(16 + extra_fmt));
			put16(flaw == FL_FORMAT ? 16'($urandom_range(65535, 2)) : 16'd1);
			put16(nch);
			put32($urandom());
			put32($urandom()); put16(16'($urandom()));
			put16(flaw == FL_BITS ? 16'd8 : 16'd16);
			repeat (extra_fmt) file_bytes.push_back(8'($urandom()));
		end
		put32(TagData);
		put32(32'(2 * nsamp + odd_tail));
		repeat (nsamp) begin
			case ($urandom_range(5))
				0: put16(16'h8000);
				1: put16(16'h7fff);
				2: put16(16'($urandom_range(2) - 1));
				default: put16(16'($urandom()));
			endcase
		end
		repeat (odd_tail) file_bytes.push_back(8'($urandom()));
		if (flaw == FL_TRUNC) begin
			k = $urandom_range(file_bytes.size() - 1, 1);
			while (file_bytes.size() > k) void'(file_bytes.pop_back());
		end
	endtask

	// Send the built file, end of stream on its final byte
	task automatic send_file();
		foreach (file_bytes[i]) begin
			@(negedge clk);
			while (!calm && $urandom_range(99) < 14) begin
				s_tvalid = 1'b0;
				@(negedge clk);
			end
			s_tvalid = 1'b1;
			s_tdata = file_bytes[i];
			s_tlast = (i == file_bytes.size() - 1);
			do @(posedge clk); while (!s_tready);
			bytes_sent++;
		end
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic play(flaw_t flaw, logic [15:0] nch, int nsamp, int odd_tail,
			int extra_fmt, bit filler);
		build_file(flaw, nch, nsamp, odd_tail, extra_fmt, filler);
		send_file();
	endtask

	initial begin
		flaw_t f;
		int    n;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: extremes, rounding, channel corner cases, each error path
		play(FL_NONE, 16'd2, 8, 0, 0, 1'b0);
		play(FL_NONE, 16'd1, 0, 0, 0, 1'b0);
		play(FL_NONE, 16'd3, 7, 1, 2, 1'b1);
		play(FL_NONE, 16'd0, 4, 1, 0, 1'b0);
		play(FL_NONE, 16'd65535, 3, 0, 1, 1'b0);
		play(FL_RIFF, 16'd1, 2, 0, 0, 1'b0);
		play(FL_WAVE, 16'd1, 2, 0, 0, 1'b0);
		play(FL_FMT_SHORT, 16'd1, 2, 0, 0, 1'b0);
		play(FL_NO_FMT, 16'd1, 2, 0, 0, 1'b1);
		play(FL_FORMAT, 16'd1, 2, 0, 0, 1'b0);
		play(FL_BITS, 16'd1, 2, 0, 0, 1'b0);
		play(FL_TRUNC, 16'd2, 6, 0, 0, 1'b1);
		play(FL_NOISE, 16'd1, 0, 0, 0, 1'b0);

		// Hold the sender until every result has drained
		wait (pending == 0);

		// Random files, mostly well formed
		while (bytes_sent < 1500) begin
			calm = (bytes_sent > 700 && bytes_sent < 1000);
			n = $urandom_range(99);
			f = (n < 70) ? FL_NONE : flaw_t'($urandom_range(FL_NOISE, FL_RIFF));
			play(f, 16'($urandom_range(4)), $urandom_range(40), $urandom_range(1),
				($urandom_range(3) == 0) ? $urandom_range(5) : 0, $urandom_range(1));
		end
		calm = 1'b0;

		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("wav_pcm16_stream_parser_downmix_unit_test: clean");
		else
			$display("wav_pcm16_stream_parser_downmix_unit_test: errors");
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("wav_pcm16_stream_parser_downmix_unit_test: errors");
		$finish;
	end

endmodule
